// File: design/tccw_pkg.sv
// tccw_pkg: shared types and constants of the text console cell writer
// field widths, command codes, character codes, controller state and
// the command/status structs between controller and datapath; no dependencies
package tccw_pkg;

    // field widths of the channels
    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    localparam int TAB_STEP = 8;

    // attribute and blank cell after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic sweep_step;
        logic load_result;
    } dp_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             need_scroll;
        logic             sweep_last;
        logic             out_free;
    } dp_status_t;

endpackage

// File: design/tccw_cmd_if.sv
// tccw_cmd_if: command channel of the text console cell writer
// valid/ready handshake with the command word; depends on tccw_pkg
interface tccw_cmd_if
    import tccw_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;

    modport source (output valid, output cmd, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input cmd, input char_code, input cell_index,
                  output ready);
endinterface

// File: design/tccw_result_if.sv
// tccw_result_if: result channel of the text console cell writer
// valid/ready handshake with the result word; depends on tccw_pkg
interface tccw_result_if
    import tccw_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [CELL_W-1:0]    read_data;
    logic                 scrolled;

    modport source (output valid, output cursor_row, output cursor_col,
                    output read_data, output scrolled, input ready);
    modport sink (input valid, input cursor_row, input cursor_col,
                  input read_data, input scrolled, output ready);
endinterface

// File: design/text_console_cell_writer.sv
// text_console_cell_writer: top level of the text-mode console cell store
// joins tccw_ctrl and tccw_datapath to the command and result channels;
// depends on tccw_pkg, tccw_cmd_if, tccw_result_if, tccw_ctrl, tccw_datapath
//
// A screen of TEXT_ROWS by TEXT_COLUMNS 16-bit cells (attribute high byte,
// character low byte) with a cursor. Each command word gives exactly one
// result word carrying the cursor after the command, the cell for a read
// and a flag for a put that scrolled. Put writes a character at the cursor
// in the current attribute and advances; newline, return and tab only move
// the cursor. Running off the last column wraps, running off the last row
// scrolls every row up and blanks the bottom row. Clear blanks all cells
// and homes the cursor. Read returns one cell, or zero for an index beyond
// the screen; command code 3 does nothing. The attribute register is
// written through cfg_write_en/cfg_write_data; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// After reset cmd_ch.ready stays low while the cell memory is filled with
// blanks, one cell a cycle. Then a put with no scroll, or an unused
// command, is accepted and executed; a read is accepted, read through the
// registered read port of the cell memory and then handed off. Scroll and
// clear sweep every cell through the single write port of the cell memory,
// which moves or blanks one cell a cycle. A result waiting on result_ch
// does not stop the next command word from being accepted; that word then
// waits for the result register before it completes.
module text_console_cell_writer
    import tccw_pkg::*;
#(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [ATTR_W-1:0]  cfg_write_data,
    tccw_cmd_if.sink           cmd_ch,
    tccw_result_if.source      result_ch
);
    // command and status between the state machine and the datapath
    dp_ctrl_t   ctrl;
    dp_status_t status;

    // state machine: reset fill, item load, execute, sweep, result hand-off
    tccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .in_ready (cmd_ch.ready),
        .ctrl     (ctrl),
        .status   (status)
    );

    // cursor, attribute register, cell memory and result register
    tccw_datapath #(
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_ROWS    (TEXT_ROWS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd_ch.cmd),
        .char_code      (cmd_ch.char_code),
        .cell_index     (cmd_ch.cell_index),
        .ctrl           (ctrl),
        .status         (status),
        .out_valid      (result_ch.valid),
        .out_ready      (result_ch.ready),
        .cursor_row     (result_ch.cursor_row),
        .cursor_col     (result_ch.cursor_col),
        .read_data      (result_ch.read_data),
        .scrolled       (result_ch.scrolled)
    );
endmodule

// File: design/tccw_ram.sv
// tccw_ram: generic single-write, single-read memory with registered read
// no dependencies
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: design/tccw_ctrl.sv
// tccw_ctrl: controller state machine of the text console cell writer
// sequences item load, execution, cell sweeps and result hand-off; depends on tccw_pkg
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output dp_ctrl_t   ctrl,
    input  dp_status_t status
);
    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                ctrl.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                priority if (status.item_cmd == CMD_CLEAR)
                begin
                    state_next = ST_SWEEP;
                end
                else if (status.item_cmd == CMD_PUT && status.need_scroll)
                begin
                    state_next = ST_SWEEP;
                end
                else if (status.item_cmd == CMD_READ)
                begin
                    // cell data is ready from the registered read port in ST_DONE
                    state_next = ST_DONE;
                end
                else if (status.out_free)
                begin
                    ctrl.load_result = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                ctrl.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.load_result = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// File: design/tccw_datapath.sv
// tccw_datapath: cursor, attribute, cell memory sweep and result register
// of the text console cell writer; depends on tccw_pkg and tccw_ram
module tccw_datapath
    import tccw_pkg::*;
#(
    parameter int TEXT_COLUMNS = 80,
    parameter int TEXT_ROWS    = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [ATTR_W-1:0]     cfg_write_data,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [INDEX_W-1:0]    cell_index,
    input  dp_ctrl_t              ctrl,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ROW_OUT_W-1:0]  cursor_row,
    output logic [COL_OUT_W-1:0]  cursor_col,
    output logic [CELL_W-1:0]     read_data,
    output logic                  scrolled
);
    localparam int CELL_COUNT = TEXT_COLUMNS * TEXT_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(TEXT_COLUMNS);
    localparam int CT_W       = CW + 1;
    localparam int RW         = $clog2(TEXT_ROWS);

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(TEXT_COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LIMIT  = ADDR_W'(CELL_COUNT - TEXT_COLUMNS);
    localparam logic [ADDR_W-1:0] SWEEP_LAST  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [CT_W-1:0]   COLS_T      = CT_W'(TEXT_COLUMNS);
    localparam logic [RW-1:0]     ROW_LAST    = RW'(TEXT_ROWS - 1);

    // item payload
    logic [CMD_W-1:0]   cmd_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [INDEX_W-1:0] index_reg;
    logic               read_hit_reg, read_hit_next;
    logic               scrolled_reg, scrolled_next;

    // cursor and attribute
    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [ADDR_W-1:0]  row_base_reg, row_base_next;
    logic [ATTR_W-1:0]  attr_reg, attr_next;

    // sweep and write-back stage
    logic [ADDR_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic               sweep_copy_reg, sweep_copy_next;
    logic [CELL_W-1:0]  blank_reg, blank_next;
    logic               wb_valid_reg, wb_valid_next;
    logic               wb_copy_reg, wb_copy_next;
    logic [ADDR_W-1:0]  wb_addr_reg, wb_addr_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [ROW_OUT_W-1:0] out_row_reg, out_row_next;
    logic [COL_OUT_W-1:0] out_col_reg, out_col_next;
    logic [CELL_W-1:0]    out_data_reg, out_data_next;
    logic                 out_scrolled_reg, out_scrolled_next;

    // memory ports
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [CELL_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [CELL_W-1:0]  ram_rd_data;

    // put-character decode
    logic               is_put;
    logic               write_cell;
    logic               row_adv;
    logic               wrap;
    logic               need_scroll;
    logic [CT_W-1:0]    col_ext;
    logic [CT_W-1:0]    col_step;
    logic [CW-1:0]      put_col;
    logic               copy_now;

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        is_put     = (cmd_reg == CMD_PUT);
        col_ext    = CT_W'(col_reg);
        write_cell = 1'b0;
        row_adv    = 1'b0;
        priority if (char_reg == CH_NEWLINE)
        begin
            col_step = '0;
            row_adv  = 1'b1;
        end
        else if (char_reg == CH_RETURN)
        begin
            col_step = '0;
        end
        else if (char_reg == CH_TAB)
        begin
            col_step = (col_ext + CT_W'(TAB_STEP)) & ~CT_W'(TAB_STEP - 1);
        end
        else
        begin
            col_step   = col_ext + CT_W'(1);
            write_cell = 1'b1;
        end
        wrap        = (col_step >= COLS_T);
        row_adv     = row_adv | wrap;
        put_col     = wrap ? '0 : CW'(col_step);
        need_scroll = row_adv && (row_reg == ROW_LAST);
    end

    assign copy_now = sweep_copy_reg && (sweep_cnt_reg < COPY_LIMIT);

    always_comb
    begin
        read_hit_next     = read_hit_reg;
        scrolled_next     = scrolled_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        row_base_next     = row_base_reg;
        attr_next         = cfg_write_en ? cfg_write_data : attr_reg;
        sweep_cnt_next    = sweep_cnt_reg;
        sweep_copy_next   = sweep_copy_reg;
        blank_next        = blank_reg;
        wb_valid_next     = 1'b0;
        wb_copy_next      = wb_copy_reg;
        wb_addr_next      = wb_addr_reg;
        out_valid_next    = out_valid_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_data_next     = out_data_reg;
        out_scrolled_next = out_scrolled_reg;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = '0;

        if (ctrl.load_item)
        begin
            read_hit_next = (cmd == CMD_READ) && (32'(cell_index) < CELL_COUNT);
            scrolled_next = 1'b0;
        end

        if (ctrl.exec)
        begin
            if (is_put)
            begin
                col_next = put_col;
                if (row_adv && !need_scroll)
                begin
                    row_next      = row_reg + RW'(1);
                    row_base_next = row_base_reg + COLS_A;
                end
                if (need_scroll)
                begin
                    scrolled_next   = 1'b1;
                    sweep_cnt_next  = '0;
                    sweep_copy_next = 1'b1;
                    blank_next      = {attr_reg, CH_SPACE};
                end
            end
            else if (cmd_reg == CMD_CLEAR)
            begin
                row_next        = '0;
                col_next        = '0;
                row_base_next   = '0;
                sweep_cnt_next  = '0;
                sweep_copy_next = 1'b0;
                blank_next      = {attr_reg, CH_SPACE};
            end
            else if (read_hit_reg)
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ADDR_W'(index_reg);
            end
        end

        if (ctrl.sweep_step)
        begin
            // read one row ahead, write back on the next cycle
            ram_rd_en      = copy_now;
            ram_rd_addr    = sweep_cnt_reg + COLS_A;
            wb_valid_next  = 1'b1;
            wb_copy_next   = copy_now;
            wb_addr_next   = sweep_cnt_reg;
            sweep_cnt_next = (sweep_cnt_reg == SWEEP_LAST) ? '0
                                                           : sweep_cnt_reg + ADDR_W'(1);
        end

        if (ctrl.load_result)
        begin
            out_valid_next    = 1'b1;
            out_row_next      = ROW_OUT_W'(row_next);
            out_col_next      = COL_OUT_W'(col_next);
            out_data_next     = read_hit_reg ? ram_rd_data : '0;
            out_scrolled_next = scrolled_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // sweep write-back and a put share the one write port at different times
    always_comb
    begin
        if (wb_valid_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wb_addr_reg;
            ram_wr_data = wb_copy_reg ? ram_rd_data : blank_reg;
        end
        else
        begin
            ram_wr_en   = ctrl.exec && is_put && write_cell;
            ram_wr_addr = row_base_reg + ADDR_W'(col_reg);
            ram_wr_data = {attr_reg, char_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            row_base_reg   <= '0;
            attr_reg       <= ATTR_RESET;
            sweep_cnt_reg  <= '0;
            sweep_copy_reg <= 1'b0;
            blank_reg      <= CELL_RESET;
            wb_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            row_reg        <= row_next;
            col_reg        <= col_next;
            row_base_reg   <= row_base_next;
            attr_reg       <= attr_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            sweep_copy_reg <= sweep_copy_next;
            blank_reg      <= blank_next;
            wb_valid_reg   <= wb_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            cmd_reg   <= cmd;
            char_reg  <= char_code;
            index_reg <= cell_index;
        end
        read_hit_reg     <= read_hit_next;
        scrolled_reg     <= scrolled_next;
        wb_copy_reg      <= wb_copy_next;
        wb_addr_reg      <= wb_addr_next;
        out_row_reg      <= out_row_next;
        out_col_reg      <= out_col_next;
        out_data_reg     <= out_data_next;
        out_scrolled_reg <= out_scrolled_next;
    end

    assign status.item_cmd    = cmd_reg;
    assign status.need_scroll = is_put && need_scroll;
    assign status.sweep_last  = (sweep_cnt_reg == SWEEP_LAST);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign read_data  = out_data_reg;
    assign scrolled   = out_scrolled_reg;
endmodule
